FILE: rtl/core/wpt_pkg.sv
// Shared types, constants and arithmetic helpers for the windowed PID controller
// with twiddle gain tuning. No dependencies; every other file imports this package.
package wpt_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_TUNE    = 2'd1,
        CMD_RESTART = 2'd2
    } wpt_cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_KP_INIT    = 2'd0,
        REG_KI_INIT    = 2'd1,
        REG_KD_INIT    = 2'd2,
        REG_WINDOW_LEN = 2'd3
    } wpt_reg_t;

    // Gain slots used by the tuner.
    localparam logic [1:0] GAIN_P = 2'd0;
    localparam logic [1:0] GAIN_I = 2'd1;
    localparam logic [1:0] GAIN_D = 2'd2;
    localparam int NUM_GAINS = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [8:0] WINDOW_RESET = 9'd100;

    localparam logic [39:0] ERR_MAX = 40'hFF_FFFF_FFFF;

    // Steer scaling: the Q46.12 sum (at MAX_WINDOW = 256) drops its twelve fraction bits.
    localparam int STEER_FRAC = 12;
    localparam int STEER_HALF = 2048;
    localparam logic signed [31:0] STEER_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] STEER_MIN = 32'sh8000_0000;

    // One percent: floor(x / 100) equals (x * PCT_RECIP) >> PCT_SHIFT for 32-bit x.
    localparam logic [31:0] PCT_RECIP = 32'd1374389535;
    localparam int PCT_SHIFT = 37;
    localparam logic [31:0] PCT_HALF = 32'd50;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  cte_sample;
    } wpt_in_t;

    typedef struct packed {
        logic signed [31:0]  steer;
        logic [39:0]         window_error;
        logic [1:0]          tune_index;
        logic                probe_pending;
        logic signed [31:0]  kp_now;
        logic signed [31:0]  ki_now;
        logic signed [31:0]  kd_now;
    } wpt_out_t;

    typedef struct packed {
        logic signed [31:0]  kp_init;
        logic signed [31:0]  ki_init;
        logic signed [31:0]  kd_init;
        logic [8:0]          window_len;
    } wpt_cfg_t;

    // One ring entry: the sample and its square, so the square leaves the window for free.
    typedef struct packed {
        logic signed [15:0]  err;
        logic [30:0]         err_sq;
    } wpt_ring_t;

    // Controller state handed to the steer pipeline after each update.
    typedef struct packed {
        logic signed [31:0]  gain_p;
        logic signed [31:0]  gain_i;
        logic signed [31:0]  gain_d;
        logic signed [15:0]  prev_err;
        logic signed [16:0]  last_diff;
        logic [39:0]         window_error;
        logic [1:0]          tune_index;
        logic                probe_pending;
    } wpt_snap_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] wpt_sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = STEER_MIN;
        end else begin
            r = STEER_MAX;
        end
        return r;
    endfunction

    // One percent of a value, rounded to nearest with ties away from zero.
    function automatic logic signed [31:0] wpt_pct(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [31:0] x;
        logic [63:0] prod;
        logic [31:0] q;
        logic signed [31:0] r;
        mag  = v[31] ? (~v + 32'd1) : v;
        x    = mag + PCT_HALF;
        prod = {32'd0, x} * {32'd0, PCT_RECIP};
        q    = {5'd0, prod[63:PCT_SHIFT]};
        r    = v[31] ? (~q + 32'd1) : q;
        return r;
    endfunction

endpackage

FILE: rtl/core/windowed_pid_with_twiddle_tuner.sv
// Top level of the windowed PID steering controller with twiddle gain tuning.
// Depends on wpt_pkg, wpt_ring, wpt_state and wpt_steer.
//
//   Port group   Direction  Handshake            Payload
//   in_*         sink       in_valid / in_stall   wpt_in_t  (command, cte_sample)
//   out_*        source     out_valid / out_stall wpt_out_t (steer, window_error, ...)
//   cfg_*        sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low. The state update for an item runs
// while it sits in the input register and the snapshot stage can take it, once the ring
// entry leaving the window has come out of the registered ring read; the steer sum then
// takes three more stages (products, sum, rounding) into the result register.
// Reset clears all control and controller state and needs no clearing pass: the ring
// is read only where the fill count shows it was written since the last restart.
// A stall at the output backs up through the stages to in_stall; no transfer is lost.
module windowed_pid_with_twiddle_tuner #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  wpt_pkg::wpt_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output wpt_pkg::wpt_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wpt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wpt_pkg::*;

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int ISW = 16 + AW;

    wpt_cfg_t           cfg_reg;
    logic               ring_wr_en;
    logic [AW-1:0]      ring_wr_addr;
    wpt_ring_t          ring_wr_data;
    logic               ring_rd_en;
    logic [AW-1:0]      ring_rd_addr;
    wpt_ring_t          ring_rd_data;
    logic               snap_valid;
    logic               snap_stall;
    wpt_snap_t          snap;
    logic signed [ISW-1:0] snap_integral;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_init    <= '0;
            cfg_reg.ki_init    <= '0;
            cfg_reg.kd_init    <= '0;
            cfg_reg.window_len <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wpt_reg_t'(cfg_index))
                REG_KP_INIT:    cfg_reg.kp_init    <= cfg_data;
                REG_KI_INIT:    cfg_reg.ki_init    <= cfg_data;
                REG_KD_INIT:    cfg_reg.kd_init    <= cfg_data;
                REG_WINDOW_LEN: cfg_reg.window_len <= cfg_data[8:0];
            endcase
        end
    end

    // Sample ring.
    wpt_ring #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // Input register and state update.
    wpt_state #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .cfg           (cfg_reg),
        .ring_wr_en    (ring_wr_en),
        .ring_wr_addr  (ring_wr_addr),
        .ring_wr_data  (ring_wr_data),
        .ring_rd_en    (ring_rd_en),
        .ring_rd_addr  (ring_rd_addr),
        .ring_rd_data  (ring_rd_data),
        .snap_valid    (snap_valid),
        .snap_stall    (snap_stall),
        .snap          (snap),
        .snap_integral (snap_integral)
    );

    // Steer computation and result register.
    wpt_steer #(
        .ISW (ISW)
    ) u_steer (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap_stall    (snap_stall),
        .snap          (snap),
        .snap_integral (snap_integral),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

FILE: rtl/core/wpt_ring.sv
// Error sample ring: one write port and one registered read port with write bypass.
// Depends on wpt_pkg for the entry type.
module wpt_ring #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
    input  wpt_pkg::wpt_ring_t            wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_addr,
    output wpt_pkg::wpt_ring_t            rd_data
);
    import wpt_pkg::*;

    wpt_ring_t ring_mem [MAX_WINDOW];
    wpt_ring_t rd_q_reg;
    wpt_ring_t byp_reg;
    logic      hit_reg;

    // Storage array with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= ring_mem[rd_addr];
            byp_reg  <= wr_data;
        end
    end

    // Remember when the read hit the entry written in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = hit_reg ? byp_reg : rd_q_reg;

endmodule

FILE: rtl/core/wpt_state.sv
// Input register and controller state update: window sums, ring pointers, twiddle tuner.
// Depends on wpt_pkg; drives the wpt_ring ports and feeds wpt_steer.
module wpt_state #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  wpt_pkg::wpt_in_t                       in_data,
    input  wpt_pkg::wpt_cfg_t                      cfg,
    output logic                                   ring_wr_en,
    output logic [$clog2(MAX_WINDOW)-1:0]          ring_wr_addr,
    output wpt_pkg::wpt_ring_t                     ring_wr_data,
    output logic                                   ring_rd_en,
    output logic [$clog2(MAX_WINDOW)-1:0]          ring_rd_addr,
    input  wpt_pkg::wpt_ring_t                     ring_rd_data,
    output logic                                   snap_valid,
    input  logic                                   snap_stall,
    output wpt_pkg::wpt_snap_t                     snap,
    output logic signed [16+$clog2(MAX_WINDOW)-1:0] snap_integral
);
    import wpt_pkg::*;

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int CW  = (WW > 9) ? WW : 9;
    localparam int ISW = 16 + AW;
    localparam int SSW = 31 + AW;
    localparam int SXW = (SSW > 40) ? SSW : 40;
    localparam logic [WW-1:0] WIN_AT_RESET = (MAX_WINDOW < int'(WINDOW_RESET)) ?
        WW'(MAX_WINDOW) : WW'(WINDOW_RESET);

    // Pipeline control.
    logic             p0_valid_reg;
    logic             p1_valid_reg;
    logic             p0_adv;
    logic             p1_ready;
    wpt_in_t          in_reg;
    logic [30:0]      esq_reg;
    logic signed [31:0] sq_in;

    // Controller state.
    logic signed [31:0]  gain_p_reg, gain_p_next;
    logic signed [31:0]  gain_i_reg, gain_i_next;
    logic signed [31:0]  gain_d_reg, gain_d_next;
    logic signed [31:0]  step_reg [NUM_GAINS];
    logic signed [31:0]  step_next [NUM_GAINS];
    logic [AW-1:0]       head_reg, head_next;
    logic [WW-1:0]       fill_reg, fill_next;
    logic [WW-1:0]       win_reg, win_next;
    logic signed [ISW-1:0] integ_reg, integ_next;
    logic signed [15:0]  prev_reg, prev_next;
    logic signed [16:0]  diff_reg, diff_next;
    logic [SSW-1:0]      square_reg, square_next;
    logic [39:0]         best_reg, best_next;
    logic [1:0]          slot_reg, slot_next;
    logic                trial_reg, trial_next;

    logic signed [31:0]  pct_in [NUM_GAINS];
    logic signed [31:0]  pct_out [NUM_GAINS];
    logic [SXW-1:0]      sq_x;
    logic [39:0]         werr;

    // Handshake: an item leaves the input register when the snapshot stage frees up.
    assign p1_ready   = !p1_valid_reg || !snap_stall;
    assign p0_adv     = p0_valid_reg && p1_ready;
    assign in_stall   = p0_valid_reg && !p1_ready;
    assign snap_valid = p1_valid_reg;
    assign ring_rd_en = in_valid && !in_stall;

    // Square of the incoming sample, registered with it.
    assign sq_in = 32'(in_data.cte_sample) * 32'(in_data.cte_sample);

    // Window squared error, saturated to 40 bits.
    assign sq_x = SXW'(square_reg);
    assign werr = (sq_x > SXW'(ERR_MAX)) ? ERR_MAX : sq_x[39:0];

    // One percent of each step size, or of each initial gain on a restart.
    always_comb
    begin
        if (in_reg.command == CMD_RESTART)
        begin
            pct_in[0] = cfg.kp_init;
            pct_in[1] = cfg.ki_init;
            pct_in[2] = cfg.kd_init;
        end
        else
        begin
            pct_in[0] = step_reg[0];
            pct_in[1] = step_reg[1];
            pct_in[2] = step_reg[2];
        end
        for (int i = 0; i < NUM_GAINS; i++)
        begin
            pct_out[i] = wpt_pct(pct_in[i]);
        end
    end

    // Next-state logic for the item in the input register.
    always_comb
    begin
        logic signed [15:0] e;
        logic signed [15:0] o;
        logic [30:0]        osq;
        logic               full;
        logic signed [31:0] g_sel;
        logic signed [31:0] s_sel;
        logic signed [31:0] p_sel;
        logic signed [31:0] g_plus;
        logic signed [31:0] g_new;
        logic signed [31:0] s_new;
        logic [1:0]         slot_after;
        logic [CW-1:0]      wl_x;

        gain_p_next = gain_p_reg;
        gain_i_next = gain_i_reg;
        gain_d_next = gain_d_reg;
        for (int i = 0; i < NUM_GAINS; i++)
        begin
            step_next[i] = step_reg[i];
        end
        head_next   = head_reg;
        fill_next   = fill_reg;
        win_next    = win_reg;
        integ_next  = integ_reg;
        prev_next   = prev_reg;
        diff_next   = diff_reg;
        square_next = square_reg;
        best_next   = best_reg;
        slot_next   = slot_reg;
        trial_next  = trial_reg;

        e    = in_reg.cte_sample;
        full = (fill_reg >= win_reg);
        o    = full ? ring_rd_data.err : 16'sd0;
        osq  = full ? ring_rd_data.err_sq : 31'd0;

        // Gain and step of the slot being tuned.
        case (slot_reg)
            GAIN_I:
            begin
                g_sel = gain_i_reg;
                s_sel = step_reg[1];
                p_sel = pct_out[1];
            end
            GAIN_D:
            begin
                g_sel = gain_d_reg;
                s_sel = step_reg[2];
                p_sel = pct_out[2];
            end
            default:
            begin
                g_sel = gain_p_reg;
                s_sel = step_reg[0];
                p_sel = pct_out[0];
            end
        endcase
        slot_after = (slot_reg == GAIN_D) ? GAIN_P : slot_reg + 2'd1;
        g_plus     = wpt_sat32(34'(g_sel) + 34'(s_sel));
        g_new      = g_sel;
        s_new      = s_sel;

        wl_x = CW'(cfg.window_len);

        if (p0_adv)
        begin
            unique case (wpt_cmd_t'(in_reg.command))
                CMD_SAMPLE:
                begin
                    // Oldest sample leaves a full window before the new one enters.
                    integ_next  = integ_reg - ISW'(o) + ISW'(e);
                    square_next = square_reg - SSW'(osq) + SSW'(esq_reg);
                    fill_next   = full ? fill_reg : fill_reg + WW'(1);
                    head_next   = (head_reg == AW'(MAX_WINDOW - 1)) ? '0 : head_reg + AW'(1);
                    diff_next   = 17'(e) - 17'(prev_reg);
                    prev_next   = e;
                end
                CMD_TUNE:
                begin
                    // One twiddle step on the current slot.
                    if (!trial_reg)
                    begin
                        g_new = g_plus;
                        if (werr <= best_reg)
                        begin
                            best_next = werr;
                            s_new     = wpt_sat32(34'(s_sel) + 34'(p_sel));
                            slot_next = slot_after;
                        end
                        else
                        begin
                            g_new      = wpt_sat32(34'(g_plus) - (34'(s_sel) <<< 1));
                            trial_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (werr < best_reg)
                        begin
                            best_next = werr;
                            s_new     = wpt_sat32(34'(s_sel) + 34'(p_sel));
                            slot_next = slot_after;
                        end
                        else
                        begin
                            g_new = g_plus;
                            s_new = wpt_sat32(34'(s_sel) - 34'(p_sel));
                        end
                        trial_next = 1'b0;
                    end
                    case (slot_reg)
                        GAIN_I:
                        begin
                            gain_i_next  = g_new;
                            step_next[1] = s_new;
                        end
                        GAIN_D:
                        begin
                            gain_d_next  = g_new;
                            step_next[2] = s_new;
                        end
                        default:
                        begin
                            gain_p_next  = g_new;
                            step_next[0] = s_new;
                        end
                    endcase
                end
                CMD_RESTART:
                begin
                    gain_p_next = cfg.kp_init;
                    gain_i_next = cfg.ki_init;
                    gain_d_next = cfg.kd_init;
                    for (int i = 0; i < NUM_GAINS; i++)
                    begin
                        step_next[i] = pct_out[i];
                    end
                    head_next   = '0;
                    fill_next   = '0;
                    integ_next  = '0;
                    prev_next   = '0;
                    diff_next   = '0;
                    square_next = '0;
                    best_next   = ERR_MAX;
                    slot_next   = GAIN_P;
                    trial_next  = 1'b0;
                    if (wl_x == '0)
                    begin
                        win_next = WW'(1);
                    end
                    else if (wl_x > CW'(MAX_WINDOW))
                    begin
                        win_next = WW'(MAX_WINDOW);
                    end
                    else
                    begin
                        win_next = WW'(wl_x);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Ring write of the new sample, and read of the entry the next item will drop.
    assign ring_wr_en   = p0_adv && (in_reg.command == CMD_SAMPLE);
    assign ring_wr_addr = head_reg;
    assign ring_wr_data = '{err: in_reg.cte_sample, err_sq: esq_reg};

    always_comb
    begin
        logic [WW:0] h_x;
        logic [WW:0] w_x;
        logic [WW:0] m_x;
        logic [WW:0] a_x;
        h_x = (WW + 1)'(head_next);
        w_x = (WW + 1)'(win_next);
        m_x = (WW + 1)'(MAX_WINDOW);
        a_x = (h_x >= w_x) ? h_x - w_x : h_x + m_x - w_x;
        ring_rd_addr = a_x[AW-1:0];
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (ring_rd_en)
        begin
            in_reg  <= in_data;
            esq_reg <= sq_in[30:0];
        end
    end

    // Control and controller state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                step_reg[i] <= '0;
            end
            head_reg     <= '0;
            fill_reg     <= '0;
            win_reg      <= WIN_AT_RESET;
            integ_reg    <= '0;
            prev_reg     <= '0;
            diff_reg     <= '0;
            square_reg   <= '0;
            best_reg     <= ERR_MAX;
            slot_reg     <= GAIN_P;
            trial_reg    <= 1'b0;
        end
        else
        begin
            if (!p0_valid_reg || p0_adv)
            begin
                p0_valid_reg <= in_valid;
            end
            if (p1_ready)
            begin
                p1_valid_reg <= p0_valid_reg;
            end
            gain_p_reg <= gain_p_next;
            gain_i_reg <= gain_i_next;
            gain_d_reg <= gain_d_next;
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                step_reg[i] <= step_next[i];
            end
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            win_reg    <= win_next;
            integ_reg  <= integ_next;
            prev_reg   <= prev_next;
            diff_reg   <= diff_next;
            square_reg <= square_next;
            best_reg   <= best_next;
            slot_reg   <= slot_next;
            trial_reg  <= trial_next;
        end
    end

    // State after the latest update, for the steer pipeline.
    assign snap = '{
        gain_p:        gain_p_reg,
        gain_i:        gain_i_reg,
        gain_d:        gain_d_reg,
        prev_err:      prev_reg,
        last_diff:     diff_reg,
        window_error:  werr,
        tune_index:    slot_reg,
        probe_pending: trial_reg
    };
    assign snap_integral = integ_reg;

`ifndef SYNTH
    // The fill count never runs past the active window.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= win_reg)
        else $error("fill count exceeds active window");

    // The tuner slot always names one of the three gains.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg == GAIN_P || slot_reg == GAIN_I || slot_reg == GAIN_D)
        else $error("tuner slot out of range");

    // A restart clears the window and the tuner history.
    assert property (@(posedge clk) disable iff (!rst_n)
        (p0_adv && in_reg.command == CMD_RESTART) |=>
        (fill_reg == '0 && head_reg == '0 && best_reg == ERR_MAX && !trial_reg))
        else $error("restart did not clear the window state");

    // The negative-direction trial only starts from a tune command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(trial_reg) |-> $past(p0_adv && in_reg.command == CMD_TUNE))
        else $error("trial flag set without a tune command");
`endif

endmodule

FILE: rtl/core/wpt_steer.sv
// Steer pipeline: three gain products, their sum, then rounding and saturation
// into the result register. Depends on wpt_pkg.
module wpt_steer #(
    parameter int ISW = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap_valid,
    output logic                   snap_stall,
    input  wpt_pkg::wpt_snap_t     snap,
    input  logic signed [ISW-1:0]  snap_integral,
    output logic                   out_valid,
    input  logic                   out_stall,
    output wpt_pkg::wpt_out_t      out_data
);
    import wpt_pkg::*;

    localparam int PIW = 32 + ISW;
    localparam int PW  = (PIW > 49) ? PIW : 49;
    localparam int ACW = PW + 2;

    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    logic               a_ready;
    logic               b_ready;
    logic               c_ready;

    logic signed [47:0]     pp_reg;
    logic signed [PIW-1:0]  pi_reg;
    logic signed [48:0]     pd_reg;
    wpt_out_t               a_item_reg;
    logic signed [ACW-1:0]  acc_reg;
    wpt_out_t               b_item_reg;
    wpt_out_t               c_item_reg;

    wpt_out_t               a_item;
    wpt_out_t               c_item;
    logic signed [ACW:0]    n;
    logic [ACW-STEER_FRAC-31:0] hi;
    logic signed [31:0]     steer_c;

    // Ready chain through the three stages.
    assign c_ready    = !c_valid_reg || !out_stall;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign snap_stall = !a_ready;

    // Status fields travel alongside the products.
    assign a_item = '{
        steer:         '0,
        window_error:  snap.window_error,
        tune_index:    snap.tune_index,
        probe_pending: snap.probe_pending,
        kp_now:        snap.gain_p,
        ki_now:        snap.gain_i,
        kd_now:        snap.gain_d
    };

    // Negate, round half up at 2^-12 and saturate to 32 bits.
    assign n  = (ACW + 1)'(STEER_HALF) - (ACW + 1)'(acc_reg);
    assign hi = n[ACW:STEER_FRAC+31];
    assign steer_c = (hi == '0 || hi == '1) ? n[STEER_FRAC+31:STEER_FRAC] :
                     (n[ACW] ? STEER_MIN : STEER_MAX);

    // Result item with the rounded steer filled in.
    always_comb
    begin
        c_item       = b_item_reg;
        c_item.steer = steer_c;
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (a_ready && snap_valid)
        begin
            pp_reg     <= 48'(snap.gain_p) * 48'(snap.prev_err);
            pi_reg     <= PIW'(snap.gain_i) * PIW'(snap_integral);
            pd_reg     <= 49'(snap.gain_d) * 49'(snap.last_diff);
            a_item_reg <= a_item;
        end
        if (b_ready && a_valid_reg)
        begin
            acc_reg    <= ACW'(pp_reg) + ACW'(pi_reg) + ACW'(pd_reg);
            b_item_reg <= a_item_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_item_reg <= c_item;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= snap_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_item_reg;

endmodule
